>>> design/pfn_pkg.sv
package pfn_pkg;

   localparam int DEF_MAX_OCTAVES = 10;
   localparam int DEF_FRAC_BITS   = 16;
   localparam int COORD_W         = 24;
   localparam int NOISE_W         = 16;
   localparam int CNT_W           = 4;
   localparam int REQ_DATA_W      = 72;
   localparam logic [CNT_W-1:0] OCT_RESET = 4'd10;

   localparam logic [7:0] PERM_ROM [256] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
      8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
      8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
      8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
      8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
      8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
      8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
      8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
      8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
      8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
      8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
      8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
      8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
      8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
      8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
      8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
      8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
      8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
      8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
      8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
      8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
      8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
   };

   function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
      return PERM_ROM[idx];
   endfunction

endpackage

>>> design/perlin_fbm_noise_3d.sv
// Fractal 3D gradient noise: each req word carries three Q8.16 coordinates
// and yields one rsp word holding the normalized noise in Q0.16, saturated at
// 65535. One word per clock is taken while the output buffer is not full;
// the path is one six-stage cell per octave in a chain followed by a
// one-bit-per-stage divider for normalization. Octaves beyond
// csr octave_count (clamped to 1..MAX_OCTAVES) pass the sum through their
// cells unchanged. A two-word output buffer takes up rsp backpressure;
// req_tready drops only while it is full. octave_count must be written with
// no words in flight.
module perlin_fbm_noise_3d import pfn_pkg::*; #(
   parameter int MAX_OCTAVES = DEF_MAX_OCTAVES,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CNT_W-1:0]      csr_wr_data,   // octave_count
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,     // coord_x, coord_y, coord_z
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [NOISE_W-1:0]    rsp_tdata      // noise_value
);

   localparam int CW = FRAC_BITS + 8;
   localparam int SW = FRAC_BITS + 2 + MAX_OCTAVES;
   localparam int KW = $clog2(MAX_OCTAVES + 1);

   logic [CNT_W-1:0]       count_ff;
   logic [KW-1:0]          k_eff;
   logic [MAX_OCTAVES-1:0] den;
   logic                   en;

   logic                   cv   [MAX_OCTAVES+1];
   logic [CW-1:0]          cc   [MAX_OCTAVES+1][3];
   logic [SW-1:0]          cacc [MAX_OCTAVES+1];

   logic                   dv;
   logic [NOISE_W-1:0]     dval;

   logic [NOISE_W-1:0]     buf_ff [2];
   logic                   wr_ptr_ff;
   logic                   rd_ptr_ff;
   logic [1:0]             cnt_ff;
   logic                   push;
   logic                   pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= OCT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         k_eff = KW'(1);
      end else if (int'(count_ff) > MAX_OCTAVES) begin
         k_eff = KW'(MAX_OCTAVES);
      end else begin
         k_eff = KW'(count_ff);
      end
      den = MAX_OCTAVES'((2**MAX_OCTAVES - 1) >> (MAX_OCTAVES - int'(k_eff)));
   end

   assign en         = cnt_ff != 2'd2;
   assign req_tready = en;

   assign cv[0]    = req_tvalid;
   assign cc[0][0] = CW'(req_tdata[COORD_W-1:0]);
   assign cc[0][1] = CW'(req_tdata[2*COORD_W-1:COORD_W]);
   assign cc[0][2] = CW'(req_tdata[3*COORD_W-1:2*COORD_W]);
   assign cacc[0]  = '0;

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
      pfn_cell #(
         .MAX_OCTAVES (MAX_OCTAVES),
         .FRAC_BITS   (FRAC_BITS),
         .IDX         (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .k_eff     (k_eff),
         .in_valid  (cv[i]),
         .in_coord  (cc[i]),
         .in_acc    (cacc[i]),
         .out_valid (cv[i+1]),
         .out_coord (cc[i+1]),
         .out_acc   (cacc[i+1])
      );
   end

   pfn_div #(
      .MAX_OCTAVES (MAX_OCTAVES),
      .FRAC_BITS   (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cv[MAX_OCTAVES]),
      .in_sum    (cacc[MAX_OCTAVES]),
      .in_den    (den),
      .out_valid (dv),
      .out_value (dval)
   );

   assign push = en && dv;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= dval;
      end
   end

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata  = buf_ff[rd_ptr_ff];

endmodule

>>> design/pfn_cell.sv
module pfn_cell import pfn_pkg::*; #(
   parameter int MAX_OCTAVES = DEF_MAX_OCTAVES,
   parameter int FRAC_BITS   = DEF_FRAC_BITS,
   parameter int IDX         = 0,
   localparam int CW = FRAC_BITS + 8,
   localparam int SW = FRAC_BITS + 2 + MAX_OCTAVES,
   localparam int KW = $clog2(MAX_OCTAVES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic [KW-1:0] k_eff,
   input  logic          in_valid,
   input  logic [CW-1:0] in_coord [3],
   input  logic [SW-1:0] in_acc,
   output logic          out_valid,
   output logic [CW-1:0] out_coord [3],
   output logic [SW-1:0] out_acc
);

   localparam int W = FRAC_BITS + 6;
   localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;

   function automatic logic signed [W-1:0] q_mul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
      logic signed [2*W-1:0] p;
      logic [2*W-1:0] m;
      logic [W-1:0] mag;
      p = a * b;
      m = p[2*W-1] ? $unsigned(-p) : $unsigned(p);
      m = m + ((2*W)'(1) << (FRAC_BITS - 1));
      mag = W'(m >> FRAC_BITS);
      return p[2*W-1] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [W-1:0] lerp(input logic signed [W-1:0] t,
                                                input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      return a + q_mul(t, b - a);
   endfunction

   function automatic logic signed [W-1:0] grad(input logic [7:0] hash,
                                                input logic signed [W-1:0] x,
                                                input logic signed [W-1:0] y,
                                                input logic signed [W-1:0] z);
      logic [3:0] h;
      logic signed [W-1:0] u;
      logic signed [W-1:0] v;
      h = hash[3:0];
      u = (h < 4'd8) ? x : y;
      v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   logic active;
   logic first;
   assign active = IDX < int'(k_eff);
   assign first  = IDX == 0;

   // stage 1
   logic                v1_ff;
   logic [CW-1:0]       cn1_ff [3];
   logic [SW-1:0]       acc1_ff;
   logic [7:0]          ip1_ff [3];
   logic signed [W-1:0] fr1_ff [3];
   logic signed [W-1:0] t2_1_ff [3];
   logic signed [W-1:0] ta_1_ff [3];
   logic [7:0]          px0_1_ff;
   logic [7:0]          px1_1_ff;
   // stage 2
   logic                v2_ff;
   logic [CW-1:0]       cn2_ff [3];
   logic [SW-1:0]       acc2_ff;
   logic [7:0]          iz2_ff;
   logic signed [W-1:0] fr2_ff [3];
   logic signed [W-1:0] t3_2_ff [3];
   logic signed [W-1:0] c_2_ff [3];
   logic [7:0]          pp2_ff [4];
   // stage 3
   logic                v3_ff;
   logic [CW-1:0]       cn3_ff [3];
   logic [SW-1:0]       acc3_ff;
   logic signed [W-1:0] fr3_ff [3];
   logic signed [W-1:0] f3_ff [3];
   logic [7:0]          h3_ff [8];
   // stage 4
   logic                v4_ff;
   logic [CW-1:0]       cn4_ff [3];
   logic [SW-1:0]       acc4_ff;
   logic signed [W-1:0] f4_ff [2];
   logic signed [W-1:0] l4_ff [4];
   // stage 5
   logic                v5_ff;
   logic [CW-1:0]       cn5_ff [3];
   logic [SW-1:0]       acc5_ff;
   logic signed [W-1:0] w5_ff;
   logic signed [W-1:0] ly5_ff [2];
   // stage 6
   logic                v6_ff;
   logic [CW-1:0]       cn6_ff [3];
   logic [SW-1:0]       acc6_ff;

   logic signed [W-1:0] fr_in [3];
   logic signed [W-1:0] six_t [3];
   logic [7:0]          a_in;
   logic [7:0]          b_in;
   logic [7:0]          hz [4];
   logic signed [W-1:0] gx [2];
   logic signed [W-1:0] gy [2];
   logic signed [W-1:0] gz [2];
   logic signed [W-1:0] g [8];
   logic signed [W-1:0] r_val;
   logic signed [W-1:0] m_val;
   logic [SW-1:0]       m_ext;
   logic [SW-1:0]       acc_in;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         fr_in[a] = $signed(W'(in_coord[a][FRAC_BITS-1:0]));
         six_t[a] = (fr_in[a] <<< 2) + (fr_in[a] <<< 1) - (ONE <<< 4) + ONE;
      end
      a_in = px0_1_ff + ip1_ff[1];
      b_in = px1_1_ff + ip1_ff[1];
      hz[0] = pp2_ff[0] + iz2_ff;
      hz[1] = pp2_ff[2] + iz2_ff;
      hz[2] = pp2_ff[1] + iz2_ff;
      hz[3] = pp2_ff[3] + iz2_ff;
      gx[0] = fr3_ff[0];
      gx[1] = fr3_ff[0] - ONE;
      gy[0] = fr3_ff[1];
      gy[1] = fr3_ff[1] - ONE;
      gz[0] = fr3_ff[2];
      gz[1] = fr3_ff[2] - ONE;
      for (int j = 0; j < 8; j++) begin
         g[j] = grad(h3_ff[j], gx[j % 2], gy[(j / 2) % 2], gz[j / 4]);
      end
      r_val = lerp(w5_ff, ly5_ff[0], ly5_ff[1]);
      m_val = r_val + ONE;
      if (m_val < 0) begin
         m_val = '0;
      end else if (m_val > (ONE <<< 1)) begin
         m_val = ONE <<< 1;
      end
      m_ext = SW'(m_val[FRAC_BITS+1:0]);
      if (!active) begin
         acc_in = acc5_ff;
      end else if (first) begin
         acc_in = m_ext;
      end else begin
         acc_in = (acc5_ff << 1) + m_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            cn1_ff[a]  <= in_coord[a] << 1;
            ip1_ff[a]  <= in_coord[a][CW-1:FRAC_BITS];
            fr1_ff[a]  <= fr_in[a];
            t2_1_ff[a] <= q_mul(fr_in[a], fr_in[a]);
            ta_1_ff[a] <= q_mul(fr_in[a], six_t[a]);
            cn2_ff[a]  <= cn1_ff[a];
            fr2_ff[a]  <= fr1_ff[a];
            t3_2_ff[a] <= q_mul(t2_1_ff[a], fr1_ff[a]);
            c_2_ff[a]  <= q_mul(fr1_ff[a], ta_1_ff[a] + (ONE <<< 3) + (ONE <<< 1));
            cn3_ff[a]  <= cn2_ff[a];
            fr3_ff[a]  <= fr2_ff[a];
            f3_ff[a]   <= q_mul(t3_2_ff[a], c_2_ff[a]);
            cn4_ff[a]  <= cn3_ff[a];
            cn5_ff[a]  <= cn4_ff[a];
            cn6_ff[a]  <= cn5_ff[a];
         end
         acc1_ff  <= in_acc;
         px0_1_ff <= perm_lookup(in_coord[0][CW-1:FRAC_BITS]);
         px1_1_ff <= perm_lookup(in_coord[0][CW-1:FRAC_BITS] + 8'd1);

         acc2_ff   <= acc1_ff;
         iz2_ff    <= ip1_ff[2];
         pp2_ff[0] <= perm_lookup(a_in);
         pp2_ff[1] <= perm_lookup(a_in + 8'd1);
         pp2_ff[2] <= perm_lookup(b_in);
         pp2_ff[3] <= perm_lookup(b_in + 8'd1);

         acc3_ff <= acc2_ff;
         for (int j = 0; j < 4; j++) begin
            h3_ff[j]     <= perm_lookup(hz[j]);
            h3_ff[j + 4] <= perm_lookup(hz[j] + 8'd1);
         end

         acc4_ff  <= acc3_ff;
         f4_ff[0] <= f3_ff[1];
         f4_ff[1] <= f3_ff[2];
         for (int n = 0; n < 4; n++) begin
            l4_ff[n] <= lerp(f3_ff[0], g[2*n], g[2*n+1]);
         end

         acc5_ff   <= acc4_ff;
         w5_ff     <= f4_ff[1];
         ly5_ff[0] <= lerp(f4_ff[0], l4_ff[0], l4_ff[1]);
         ly5_ff[1] <= lerp(f4_ff[0], l4_ff[2], l4_ff[3]);

         acc6_ff <= acc_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_coord = cn6_ff;
   assign out_acc   = acc6_ff;

endmodule

>>> design/pfn_div.sv
module pfn_div import pfn_pkg::*; #(
   parameter int MAX_OCTAVES = DEF_MAX_OCTAVES,
   parameter int FRAC_BITS   = DEF_FRAC_BITS,
   localparam int SW = FRAC_BITS + 2 + MAX_OCTAVES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [SW-1:0]          in_sum,
   input  logic [MAX_OCTAVES-1:0] in_den,
   output logic                   out_valid,
   output logic [NOISE_W-1:0]     out_value
);

   localparam int QB = NOISE_W + 1;
   localparam int RW = MAX_OCTAVES + NOISE_W + 2;
   localparam int NW = SW + NOISE_W + 1;

   logic [NW-1:0]          num;
   logic                   v_ff   [QB+1];
   logic [RW-1:0]          rem_ff [QB+1];
   logic [MAX_OCTAVES-1:0] d_ff   [QB+1];
   logic [QB-1:0]          q_ff   [QB+1];

   assign num = (NW'(in_sum) << NOISE_W) + (NW'(in_den) << FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(num >> (FRAC_BITS + 1));
         d_ff[0]   <= in_den;
         q_ff[0]   <= '0;
      end
   end

   for (genvar j = 0; j < QB; j++) begin : g_step
      logic [RW-1:0] dsh;
      logic          ge;
      assign dsh = RW'(d_ff[j]) << (QB - 1 - j);
      assign ge  = rem_ff[j] >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (en) begin
            v_ff[j+1] <= v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= ge ? rem_ff[j] - dsh : rem_ff[j];
            d_ff[j+1]   <= d_ff[j];
            q_ff[j+1]   <= q_ff[j] | (QB'(ge) << (QB - 1 - j));
         end
      end
   end

   assign out_valid = v_ff[QB];
   assign out_value = q_ff[QB][QB-1] ? '1 : q_ff[QB][NOISE_W-1:0];

endmodule
